// ===== hdl/wcws_pkg.sv =====
`timescale 1ns / 1ps
package wcws_pkg;

   // channel store
   localparam int CHANNELS = 16;
   localparam int CH_W     = 4;

   // voltage limits, 1/1024 V units
   localparam int VMAX    = 10240;
   localparam int STEPMAX = 5120;
   localparam int HI_TH   = 1024;
   localparam int LO_TH   = 102;
   localparam int ACC_RST = 1024;

   // csr register indexes
   localparam logic [1:0] CSR_INVERT_MODE = 2'd0;
   localparam logic [1:0] CSR_QUANT_DIV   = 2'd1;
   localparam logic [1:0] CSR_GAIN        = 2'd2;

   // divider length
   localparam int DIV_BITS = 20;

   typedef struct packed {
      logic [3:0]         channel;
      logic               external_mode;
      logic signed [14:0] compare_in;
      logic signed [14:0] invert_level;
      logic signed [14:0] trigger_level;
      logic signed [14:0] reset_level;
      logic signed [14:0] window_bias;
      logic signed [14:0] window_range;
      logic signed [14:0] step_amount;
      logic               manual_trigger;
      logic               manual_reset;
   } req_type;

   typedef struct packed {
      logic signed [14:0] acc;
      logic               above;
      logic               below;
   } upd_type;

endpackage

// ===== hdl/wcws_req_if.sv =====
`timescale 1ns / 1ps
interface wcws_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         channel;
   logic               external_mode;
   logic signed [14:0] compare_in;
   logic signed [14:0] invert_level;
   logic signed [14:0] trigger_level;
   logic signed [14:0] reset_level;
   logic signed [14:0] window_bias;
   logic signed [14:0] window_range;
   logic signed [14:0] step_amount;
   logic               manual_trigger;
   logic               manual_reset;
   modport source (output valid, channel, external_mode, compare_in, invert_level,
      trigger_level, reset_level, window_bias, window_range, step_amount,
      manual_trigger, manual_reset, input ready);
   modport sink (input valid, channel, external_mode, compare_in, invert_level,
      trigger_level, reset_level, window_bias, window_range, step_amount,
      manual_trigger, manual_reset, output ready);
endinterface

// ===== hdl/wcws_rsp_if.sv =====
`timescale 1ns / 1ps
interface wcws_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         out_channel;
   logic signed [14:0] stepper_out;
   logic               above_window;
   logic               below_window;
   modport source (output valid, out_channel, stepper_out, above_window, below_window,
      input ready);
   modport sink (input valid, out_channel, stepper_out, above_window, below_window,
      output ready);
endinterface

// ===== hdl/wcws_core.sv =====
`timescale 1ns / 1ps
module wcws_core import wcws_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               invert_mode,
   input  logic signed [11:0] gain,
   input  req_type            req,
   input  logic               update,
   output upd_type            upd
);

   logic signed [14:0] acc_ff     [CHANNELS];
   logic               toggle_ff  [CHANNELS];
   logic               prev_ff    [CHANNELS];
   logic               trig_st_ff [CHANNELS];
   logic               rst_st_ff  [CHANNELS];

   logic [CH_W-1:0]    idx;
   logic signed [14:0] bias_c, step_c, estep, acc_cur, rng, add, acc_in;
   logic signed [15:0] rng_abs;
   logic signed [16:0] hi2, lo2, acc2, sum;
   logic signed [27:0] prod;
   logic signed [28:0] x2, hix, lox;
   logic               inv_high, toggle_in, invert, above, below, corr_en;
   logic               trig_in, trig_fire, rst_in, rst_fire, trig, rst;

   assign idx = req.channel[CH_W-1:0];

   // clamp the window and step controls
   always_comb begin
      bias_c = req.window_bias;
      if (req.window_bias > 15'(VMAX)) bias_c = 15'(VMAX);
      if (req.window_bias < -15'(VMAX)) bias_c = -15'(VMAX);
      rng_abs = req.window_range[14] ? -16'(req.window_range) : 16'(req.window_range);
      rng = (rng_abs > 16'(VMAX)) ? 15'(VMAX) : rng_abs[14:0];
      step_c = req.step_amount;
      if (req.step_amount > 15'(STEPMAX)) step_c = 15'(STEPMAX);
      if (req.step_amount < -15'(STEPMAX)) step_c = -15'(STEPMAX);
   end

   // invert source
   always_comb begin
      inv_high  = req.invert_level > 15'(HI_TH);
      toggle_in = toggle_ff[idx] ^ (inv_high & ~prev_ff[idx]);
      invert    = invert_mode ? toggle_in : (req.invert_level > 15'sd0);
      estep     = invert ? -step_c : step_c;
   end

   // window compare
   always_comb begin
      acc_cur = acc_ff[idx];
      hi2  = (17'(bias_c) <<< 1) + 17'(rng);
      lo2  = (17'(bias_c) <<< 1) - 17'(rng);
      acc2 = 17'(acc_cur) <<< 1;
      prod = 28'(req.compare_in) * 28'(gain);
      x2   = 29'(prod) <<< 1;
      hix  = 29'(hi2) <<< 10;
      lox  = 29'(lo2) <<< 10;
      above = 1'b0;
      below = 1'b0;
      if (req.external_mode) begin
         above = x2 > hix;
         below = !above && (x2 < lox);
      end else if (!estep[14]) begin
         above = acc2 >= hi2;
         below = !above && (acc2 < lo2);
      end else begin
         above = acc2 > hi2;
         below = !above && (acc2 <= lo2);
      end
   end

   // schmitt triggers
   always_comb begin
      trig_in   = trig_st_ff[idx] ? !(req.trigger_level <= 15'(LO_TH))
                                  : (req.trigger_level >= 15'(HI_TH));
      trig_fire = !trig_st_ff[idx] && (req.trigger_level >= 15'(HI_TH));
      rst_in    = rst_st_ff[idx] ? !(req.reset_level <= 15'(LO_TH))
                                 : (req.reset_level >= 15'(HI_TH));
      rst_fire  = !rst_st_ff[idx] && (req.reset_level >= 15'(HI_TH));
      trig = trig_fire | req.manual_trigger;
      rst  = rst_fire | req.manual_reset;
   end

   // accumulator update
   always_comb begin
      corr_en = !req.external_mode && (above || below) && (rng != 15'sd0);
      if (corr_en) add = above ? -rng : rng;
      else add = estep;
      sum = 17'(acc_cur) + 17'(add);
      if (rst) acc_in = req.external_mode ? 15'sd0 : bias_c;
      else if (trig) begin
         if (sum > 17'(VMAX)) acc_in = 15'(VMAX);
         else if (sum < -17'(VMAX)) acc_in = -15'(VMAX);
         else acc_in = sum[14:0];
      end else acc_in = acc_cur;
      upd.acc   = acc_in;
      upd.above = above;
      upd.below = below;
   end

   // channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            acc_ff[i]     <= 15'(ACC_RST);
            toggle_ff[i]  <= 1'b0;
            prev_ff[i]    <= 1'b0;
            trig_st_ff[i] <= 1'b0;
            rst_st_ff[i]  <= 1'b0;
         end
      end else if (update) begin
         acc_ff[idx]     <= acc_in;
         trig_st_ff[idx] <= trig_in;
         rst_st_ff[idx]  <= rst_in;
         if (invert_mode) begin
            toggle_ff[idx] <= toggle_in;
            prev_ff[idx]   <= inv_high;
         end
      end
   end

endmodule

// ===== hdl/wcws_quant.sv =====
`timescale 1ns / 1ps
module wcws_quant import wcws_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [14:0] value,
   input  logic [5:0]         divs,
   output logic               done,
   output logic signed [14:0] result
);

   localparam logic [1:0] Q_IDLE = 2'd0;
   localparam logic [1:0] Q_LOAD = 2'd1;
   localparam logic [1:0] Q_DIV  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic signed [14:0] v_ff;
   logic [5:0]         d_ff;
   logic               neg_ff;
   logic [DIV_BITS-1:0] q_ff, q_in;
   logic [6:0]         rem_ff, rem_in, trial;
   logic [4:0]         cnt_ff, cnt_in;
   logic signed [21:0] prod;
   logic [21:0]        mag, rnd;
   logic [DIV_BITS-1:0] num, qs;
   logic               done_ff, done_in;
   logic signed [14:0] res_ff, res_in;
   logic               ge;

   // scale and round to the grid index
   always_comb begin
      prod = 22'(v_ff) * 22'($signed({1'b0, d_ff}));
      mag  = prod[21] ? 22'(-prod) : 22'(prod);
      rnd  = mag + 22'd512;
      num  = {rnd[19:10], 10'd0} + DIV_BITS'(d_ff >> 1);
   end

   // one quotient bit per cycle
   always_comb begin
      trial = {rem_ff[5:0], q_ff[DIV_BITS-1]};
      ge    = trial >= {1'b0, d_ff};
      qs    = {q_ff[DIV_BITS-2:0], ge};
   end

   always_comb begin
      state_in = state_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      case (state_ff)
         Q_IDLE: begin
            if (start) begin
               if (divs == 6'd0) begin
                  done_in = 1'b1;
                  res_in  = value;
               end else state_in = Q_LOAD;
            end
         end
         Q_LOAD: begin
            q_in     = num;
            rem_in   = 7'd0;
            cnt_in   = 5'd0;
            state_in = Q_DIV;
         end
         Q_DIV: begin
            q_in   = qs;
            rem_in = ge ? trial - {1'b0, d_ff} : trial;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_BITS - 1)) begin
               done_in  = 1'b1;
               res_in   = neg_ff ? -15'(qs) : 15'(qs);
               state_in = Q_IDLE;
            end
         end
         default: state_in = Q_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Q_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && state_ff == Q_IDLE) begin
         v_ff   <= value;
         d_ff   <= divs;
         neg_ff <= value[14];
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

`ifndef SYNTHESIS
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == Q_DIV |-> rem_ff < {1'b0, d_ff})
      else $error("divider remainder out of range");
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (res_ff <= 15'(VMAX) && res_ff >= -15'(VMAX)))
      else $error("quantized result out of range");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("done held longer than one cycle");
`endif

endmodule

// ===== hdl/window_comparator_wrap_stepper.sv =====
`timescale 1ns / 1ps
// channel | dir | handshake   | payload
// req_bus | in  | valid/ready | channel, mode, levels, window, step, manual bits
// rsp_bus | out | valid/ready | out_channel, stepper_out, above/below flags
// csr     | in  | csr_we      | csr_index, csr_wdata (12 bits)
// one request at a time: capture, the channel update, then the quantizer
// (20-bit serial divider, bypassed when the divisor is zero); the result is then
// registered onto rsp_bus, and only after that is the next request taken
// reset (synchronous) sets every accumulator to 1 V and clears all latches
// a result held on rsp_bus stalls only the finish of the following request
module window_comparator_wrap_stepper import wcws_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   wcws_req_if.sink    req_bus,
   wcws_rsp_if.source  rsp_bus,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CALC  = 2'd1;
   localparam logic [1:0] S_QUANT = 2'd2;
   localparam logic [1:0] S_OUT   = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic               mode_ff;
   logic [5:0]         divs_ff;
   logic signed [11:0] gain_ff;
   req_type            req_ff;
   upd_type            upd, upd_ff;
   logic               q_done;
   logic signed [14:0] q_res, hold_ff;
   logic               accept, rsp_valid_ff, out_free;
   logic [3:0]         out_ch_ff;
   logic signed [14:0] out_val_ff;
   logic               out_above_ff, out_below_ff;

   assign accept   = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         divs_ff <= 6'd0;
         gain_ff <= 12'sd1024;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INVERT_MODE: mode_ff <= csr_wdata[0];
            CSR_QUANT_DIV:   divs_ff <= csr_wdata[5:0];
            CSR_GAIN:        gain_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.channel        <= req_bus.channel;
         req_ff.external_mode  <= req_bus.external_mode;
         req_ff.compare_in     <= req_bus.compare_in;
         req_ff.invert_level   <= req_bus.invert_level;
         req_ff.trigger_level  <= req_bus.trigger_level;
         req_ff.reset_level    <= req_bus.reset_level;
         req_ff.window_bias    <= req_bus.window_bias;
         req_ff.window_range   <= req_bus.window_range;
         req_ff.step_amount    <= req_bus.step_amount;
         req_ff.manual_trigger <= req_bus.manual_trigger;
         req_ff.manual_reset   <= req_bus.manual_reset;
      end
      if (state_ff == S_CALC) upd_ff <= upd;
      if (q_done) hold_ff <= q_res;
   end

   wcws_core u_core (
      .clock       (clock),
      .reset       (reset),
      .invert_mode (mode_ff),
      .gain        (gain_ff),
      .req         (req_ff),
      .update      (state_ff == S_CALC),
      .upd         (upd)
   );

   wcws_quant u_quant (
      .clock  (clock),
      .reset  (reset),
      .start  (state_ff == S_CALC),
      .value  (upd.acc),
      .divs   (divs_ff),
      .done   (q_done),
      .result (q_res)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_CALC;
         S_CALC:  state_in = S_QUANT;
         S_QUANT: if (q_done) state_in = S_OUT;
         S_OUT:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_bus.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && out_free) begin
         out_ch_ff    <= req_ff.channel;
         out_val_ff   <= hold_ff;
         out_above_ff <= upd_ff.above;
         out_below_ff <= upd_ff.below;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_channel  = out_ch_ff;
   assign rsp_bus.stepper_out  = out_val_ff;
   assign rsp_bus.above_window = out_above_ff;
   assign rsp_bus.below_window = out_below_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_CALC)
      else $error("request accepted without starting an update");
   a_done_in_quant: assert property (@(posedge clock) disable iff (reset)
      q_done |-> state_ff == S_QUANT)
      else $error("quantizer finished outside its phase");
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(out_above_ff && out_below_ff))
      else $error("above and below both set");
`endif

endmodule
